// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define KPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define KPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define KPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/kpe_pkg.sv
// ---------------------------------------------------------------------------
// kpe_pkg
// key codes, decode functions and controller/datapath interface types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpe_pkg;

    // key codes
    typedef logic [4:0] t_key;

    localparam t_key KEY_NONE   = 5'd20;
    localparam t_key KEY_DELETE = 5'd10;
    localparam t_key KEY_SUBMIT = 5'd11;

    // debounce register
    localparam int          DEB_W     = 16;
    localparam logic [15:0] DEB_RESET = 16'd50;

    // output word layout
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic emit_load;  // load next result word into the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit_req;   // the presented word starts a submission
        logic out_free;   // output register can take a word
        logic emit_last;  // word being loaded closes the submission
    } t_dp_status;

    // column priority encode, column 1 first, 0 when no column reads high
    function automatic logic [1:0] col_encode(input logic [2:0] levels);
        logic [1:0] col;
        col = 2'd0;
        if (levels[0]) begin
            col = 2'd1;
        end else if (levels[1]) begin
            col = 2'd2;
        end else if (levels[2]) begin
            col = 2'd3;
        end
        return col;
    endfunction

    // row/column to key code
    function automatic t_key map_key(input logic [1:0] row, input logic [1:0] col);
        t_key key;
        if (col == 2'd0) begin
            key = KEY_NONE;
        end else if (row != 2'd3) begin
            key = t_key'({1'b0, row} * 3'd3) + t_key'(col);
        end else if (col == 2'd1) begin
            key = KEY_DELETE;
        end else begin
            key = KEY_SUBMIT;
        end
        return key;
    endfunction

endpackage

// File: rtl/kpe_ctrl.sv
// ---------------------------------------------------------------------------
// kpe_ctrl
// sequencer: takes one word at a time, walks the digit store on a submit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kpe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kpe_pkg::t_dp_status i_status,
    output kpe_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.emit_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.emit_req) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/kpe_dpath.sv
// ---------------------------------------------------------------------------
// kpe_dpath
// lockout timer, key decode, digit store and result output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kpe_dpath #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [kpe_pkg::DEB_W-1:0]           i_debounce,
    input  logic                                i_opcode,
    input  logic [1:0]                          i_row,
    input  logic [2:0]                          i_levels,
    input  kpe_pkg::t_ctrl_cmd                  i_cmd,
    output kpe_pkg::t_dp_status                 o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [3:0]                          o_digit,
    output logic [3:0]                          o_position,
    output logic [4:0]                          o_pin_length,
    output logic                                o_empty,
    output logic                                o_cause,
    output logic                                o_last
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                       r_lock_active;
    logic [kpe_pkg::DEB_W-1:0]  r_lock_count;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              n_idx;
    logic                       r_cause;
    logic [3:0]                 r_rd_data;
    logic [3:0]                 r_mem [MAX_DIGITS];

    logic                       r_out_valid;
    logic [3:0]                 r_digit;
    logic [3:0]                 r_position;
    logic [4:0]                 r_pin_length;
    logic                       r_empty;
    logic                       r_cause_out;
    logic                       r_last;

    logic                       w_press;
    kpe_pkg::t_key              w_key;
    logic                       w_is_digit;
    logic                       w_full;
    logic                       w_wr_en;
    logic                       w_emit_empty;
    logic                       w_emit_last;

    // key decode of the presented word
    assign w_key      = kpe_pkg::map_key(i_row, kpe_pkg::col_encode(i_levels));
    assign w_press    = i_opcode && !r_lock_active;
    assign w_is_digit = (w_key != kpe_pkg::KEY_NONE) && (w_key != kpe_pkg::KEY_DELETE)
                        && (w_key != kpe_pkg::KEY_SUBMIT);
    assign w_full     = (r_count >= CW'(MAX_DIGITS));
    assign w_wr_en    = i_cmd.accept && w_press && w_is_digit && !w_full;

    // submission walk
    assign w_emit_empty = (r_count == '0);
    assign w_emit_last  = w_emit_empty || ({1'b0, r_idx} + 1'b1 == {1'b0, r_count});

    assign o_status.emit_req  = w_press && ((w_key == kpe_pkg::KEY_SUBMIT)
                                || (w_is_digit && w_full));
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = w_emit_last;

    // next read index, so the registered read data tracks r_idx
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.emit_load) begin
            n_idx = w_emit_last ? '0 : r_idx + 1'b1;
        end
    end

    // lockout timer, digit count and submission state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_active <= 1'b0;
            r_lock_count  <= '0;
            r_count       <= '0;
            r_idx         <= '0;
            r_cause       <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.accept) begin
                if (!i_opcode) begin
                    // tick
                    if (r_lock_active) begin
                        if (r_lock_count <= kpe_pkg::DEB_W'(1)) begin
                            r_lock_count  <= '0;
                            r_lock_active <= 1'b0;
                        end else begin
                            r_lock_count <= r_lock_count - 1'b1;
                        end
                    end
                end else if (!r_lock_active) begin
                    // accepted press
                    r_lock_active <= 1'b1;
                    r_lock_count  <= i_debounce;
                    r_cause       <= (w_key != kpe_pkg::KEY_SUBMIT);
                    if (w_key == kpe_pkg::KEY_DELETE && r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end else if (w_wr_en) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end else if (i_cmd.emit_load && w_emit_last) begin
                r_count <= '0;
            end
        end
    end

    // digit store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= w_key[3:0];
        end
        r_rd_data <= r_mem[n_idx[AW-1:0]];
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_digit      <= w_emit_empty ? 4'd0 : r_rd_data;
            r_position   <= 4'(r_idx);
            r_pin_length <= 5'(r_count);
            r_empty      <= w_emit_empty;
            r_cause_out  <= r_cause;
            r_last       <= w_emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit      = r_digit;
    assign o_position   = r_position;
    assign o_pin_length = r_pin_length;
    assign o_empty      = r_empty;
    assign o_cause      = r_cause_out;
    assign o_last       = r_last;

endmodule

// File: rtl/keypad_pin_entry.sv
// ---------------------------------------------------------------------------
// keypad_pin_entry
// pin entry from a 4x3 matrix keypad with debounce lockout
// ---------------------------------------------------------------------------
// usage:
//   input stream: one word per tick (tuser 0) or row press (tuser 1); a press
//   during the lockout is dropped, any other press re-arms it for
//   debounce_ticks ticks. digits 1-9 fill the pin store, star deletes one,
//   row 4 columns 2/3 submit; a digit on a full store submits it instead.
//   output stream: one word per stored digit with tlast on the final one, or
//   a single word flagged empty when nothing was stored.
//   flow: a tick or a non-submitting press is taken while idle; a submission
//   is accepted and then emits its result words (up to MAX_DIGITS), paced
//   by the single read port of the digit store and the output register.
//   s_axis_tready is low while results are being emitted; a stall on the
//   output side holds the output register and pauses the walk.
//   reset (synchronous, active low): lockout off, store empty, debounce 50.
//   register 0 (byte address 0): debounce_ticks, written over the apb port
//   by the user only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module keypad_pin_entry #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [kpe_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // row_index[1:0], column_levels[4:2]
    input  logic                                s_axis_tuser,   // opcode
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kpe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // digit[3:0], position[7:4], pin_length[12:8]
    output logic [kpe_pkg::OUT_USER_W-1:0]      m_axis_tuser,   // empty_res[0], cause[1]
    output logic                                m_axis_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [kpe_pkg::DEB_W-1:0]  r_debounce;
    kpe_pkg::t_ctrl_cmd         w_cmd;
    kpe_pkg::t_dp_status        w_status;
    logic [3:0]                 w_digit;
    logic [3:0]                 w_position;
    logic [4:0]                 w_pin_length;
    logic                       w_empty;
    logic                       w_cause;
    logic                       w_cfg_wr;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kpe_pkg::DEB_RESET;
        end else if (w_cfg_wr) begin
            r_debounce <= pwdata[kpe_pkg::DEB_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32 - kpe_pkg::DEB_W){1'b0}}, r_debounce} : 32'd0;

    // sequencer
    kpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    kpe_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_debounce   (r_debounce),
        .i_opcode     (s_axis_tuser),
        .i_row        (s_axis_tdata[1:0]),
        .i_levels     (s_axis_tdata[4:2]),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_digit      (w_digit),
        .o_position   (w_position),
        .o_pin_length (w_pin_length),
        .o_empty      (w_empty),
        .o_cause      (w_cause),
        .o_last       (m_axis_tlast)
    );

    // output word packing
    assign m_axis_tdata = {3'd0, w_pin_length, w_position, w_digit};
    assign m_axis_tuser = {w_cause, w_empty};

    // no result word is loaded while the block is taking input
    `KPE_ASSERT_IMP(a_no_emit_when_ready, i_clk, i_rst_n, s_axis_tready, !w_cmd.emit_load)

    // a submitting press makes the block busy on the next cycle
    `KPE_ASSERT_NXT(a_busy_after_submit, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && w_status.emit_req, !s_axis_tready)

    // a result word is loaded only into a free output register
    `KPE_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n,
        w_cmd.emit_load, !m_axis_tvalid || m_axis_tready)

    // a register write lands in the debounce register
    `KPE_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, w_cfg_wr,
        r_debounce == $past(pwdata[kpe_pkg::DEB_W-1:0]))

endmodule
